// File: rtl/core/md5_pkg.sv
package md5_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_OFFSET = 56;

  // Byte source selects for a buffer write
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      wr_en;
    byte_src_t wr_src;
    logic [5:0] wr_addr;
    logic      count_inc;
    logic      round_start;
    logic      round_step;
    logic      chain_update;
    logic      digest_load;
    logic      state_init;
  } md5_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [5:0] byte_ptr;
    logic [5:0] round_idx;
  } md5_stat_t;

  function automatic logic [31:0] step_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/md5_message_digest.sv
// MD5 engine. Each transaction on the input absorbs one byte (func 0) or
// finishes the message (func 1). An absorbed byte is written to the block
// buffer; the 64th byte of a block starts a compression (64 steps on one
// round unit plus load and add). Finish pads and compresses once or twice,
// then offers the digest; the engine then returns to the initial chaining
// values and a zero count. Input stalls while busy.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_first_half,
  output logic [63:0] digest_second_half
);

  md5_cmd_t  cmd;
  md5_stat_t stat;

  md5_control u_ctrl (
    .clk, .rst, .in_valid, .func, .in_stall, .out_stall, .out_valid,
    .stat, .cmd
  );

  md5_datapath u_dp (
    .clk, .rst, .cmd, .data_byte, .stat, .digest_first_half, .digest_second_half
  );

  // Never accept input while a digest is waiting
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input accepted with digest pending");

  // Round steps only run while input is held off
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.round_step |-> in_stall) else $error("compression while accepting");

  // A delivered digest returns the count to zero
  a_reset_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (stat.byte_ptr == 6'd0))
    else $error("count not cleared after digest");

endmodule

// File: rtl/core/md5_datapath.sv
module md5_datapath
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  md5_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  output md5_stat_t   stat,
  output logic [63:0] digest_first_half,
  output logic [63:0] digest_second_half
);

  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] words [16];
  logic [63:0] byte_count;
  logic [5:0]  round_idx;
  logic [7:0]  wr_byte;
  logic [63:0] bit_len;
  logic [1:0]  round;
  logic [3:0]  g;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;

  assign bit_len = {byte_count[60:0], 3'b000};

  // Select the byte written into the block buffer
  always_comb begin
    case (cmd.wr_src)
      SRC_DATA: wr_byte = data_byte;
      SRC_PAD:  wr_byte = PAD_BYTE;
      SRC_ZERO: wr_byte = 8'h00;
      default:  wr_byte = bit_len[{cmd.wr_addr[2:0], 3'b000} +: 8];
    endcase
  end

  // Block buffer held as little-endian words
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      words[cmd.wr_addr[5:2]][{cmd.wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  // One compression step
  always_comb begin
    round = round_idx[5:4];
    case (round)
      2'd0: begin
        f = wd ^ (wb & (wc ^ wd));
        g = round_idx[3:0];
      end
      2'd1: begin
        f = wc ^ (wd & (wb ^ wc));
        g = 4'(round_idx[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = wb ^ wc ^ wd;
        g = 4'(round_idx[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = wc ^ (wb | ~wd);
        g = 4'(round_idx[3:0] * 4'd7);
      end
    endcase
    sum = wa + f + words[g] + step_const(round_idx);
    sh  = rot_amount({round, round_idx[1:0]});
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  // Working and chaining registers
  always_ff @(posedge clk) begin
    if (rst || cmd.state_init) begin
      chain[0] <= IV0;
      chain[1] <= IV1;
      chain[2] <= IV2;
      chain[3] <= IV3;
      byte_count <= '0;
      round_idx <= '0;
    end else begin
      if (cmd.count_inc) begin
        byte_count <= byte_count + 64'd1;
      end
      if (cmd.round_start) begin
        wa <= chain[0];
        wb <= chain[1];
        wc <= chain[2];
        wd <= chain[3];
        round_idx <= '0;
      end else if (cmd.round_step) begin
        wa <= wd;
        wd <= wc;
        wc <= wb;
        wb <= rot + wb;
        round_idx <= round_idx + 6'd1;
      end
      if (cmd.chain_update) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end
    end
  end

  // Capture the digest from the final add
  always_ff @(posedge clk) begin
    if (cmd.digest_load) begin
      digest_first_half  <= {chain[1] + wb, chain[0] + wa};
      digest_second_half <= {chain[3] + wd, chain[2] + wc};
    end
  end

  assign stat.byte_ptr  = byte_count[5:0];
  assign stat.round_idx = round_idx;

endmodule

// File: rtl/core/md5_control.sv
module md5_control
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      func,
  output logic      in_stall,
  input  logic      out_stall,
  output logic      out_valid,
  input  md5_stat_t stat,
  output md5_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_FILL  = 7'b0000100,
    S_START = 7'b0001000,
    S_RUN   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic       finishing, finishing_next;
  logic       last_block, last_block_next;
  logic [5:0] ptr, ptr_next;
  logic       acc;

  assign in_stall  = (state != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next      = state;
    finishing_next  = finishing;
    last_block_next = last_block;
    ptr_next        = ptr;
    cmd             = '0;
    cmd.wr_src      = SRC_DATA;
    case (state)
      S_IDLE: begin
        if (acc && !func) begin
          // Absorb one byte, compress when the block fills
          cmd.wr_en     = 1'b1;
          cmd.wr_addr   = stat.byte_ptr;
          cmd.count_inc = 1'b1;
          if (stat.byte_ptr == 6'd63) begin
            state_next     = S_START;
            finishing_next = 1'b0;
          end
        end else if (acc) begin
          state_next     = S_PAD;
          finishing_next = 1'b1;
        end
      end
      S_PAD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = SRC_PAD;
        cmd.wr_addr = stat.byte_ptr;
        ptr_next    = stat.byte_ptr + 6'd1;
        last_block_next = (stat.byte_ptr < 6'(LEN_OFFSET));
        state_next  = (stat.byte_ptr == 6'd63) ? S_START : S_FILL;
      end
      S_FILL: begin
        // Zero fill, then on the last block the length in the last eight bytes
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = ptr;
        cmd.wr_src  = (last_block && ptr >= 6'(LEN_OFFSET)) ? SRC_LEN : SRC_ZERO;
        ptr_next    = ptr + 6'd1;
        if (ptr == 6'd63) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.round_start = 1'b1;
        state_next      = S_RUN;
      end
      S_RUN: begin
        cmd.round_step = 1'b1;
        if (stat.round_idx == 6'd63) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.chain_update = 1'b1;
        if (!finishing) begin
          state_next = S_IDLE;
        end else if (!last_block) begin
          last_block_next = 1'b1;
          ptr_next        = '0;
          state_next      = S_FILL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.state_init = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Digest register follows the chain after the final add
    cmd.digest_load = (state == S_ADD) && finishing && last_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      finishing  <= 1'b0;
      last_block <= 1'b0;
      ptr        <= '0;
    end else begin
      state      <= state_next;
      finishing  <= finishing_next;
      last_block <= last_block_next;
      ptr        <= ptr_next;
    end
  end

endmodule

// File: sim/tb_md5_message_digest.sv
module tb_md5_message_digest;
  import md5_pkg::*;

  localparam logic FN_ABSORB = 1'b0;
  localparam logic FN_FINISH = 1'b1;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FN_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] digest_first_half;
  logic [63:0] digest_second_half;

  md5_message_digest dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_first_half(digest_first_half),
    .digest_second_half(digest_second_half)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  typedef struct {
    logic        fn;
    logic [7:0]  byte_val;
    logic        has_digest;
    logic [63:0] lo;
    logic [63:0] hi;
  } stim_row_t;

  // Predictor state
  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [63:0] msg_len;
  digest_t     pending_digests [$];

  int  errors = 0;
  int  idle_cycles = 0;

  function automatic logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic init_chain();
    chain[0] = IV0; chain[1] = IV1; chain[2] = IV2; chain[3] = IV3;
    msg_len = 64'd0;
  endtask

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int g, rnd;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    for (int i = 0; i < 64; i++) begin
      rnd = i >> 4;
      case (rnd)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = (5*i + 1) & 15; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) & 15; end
        default: begin f = c ^ (b | ~d); g = (7*i) & 15; end
      endcase
      t = a + f + w[g] + step_const(i[5:0]);
      t = rotl(t, rot_amount({rnd[1:0], i[1:0]})) + b;
      a = d; d = c; c = b; b = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  // Advance the predictor by one accepted transaction
  task automatic predict_digest(logic fn, logic [7:0] byte_val);
    int used;
    logic [63:0] bits;
    digest_t dg;
    if (fn == FN_ABSORB) begin
      blk[msg_len[5:0]] = byte_val;
      msg_len++;
      if (msg_len[5:0] == 6'd0) compress();
      return;
    end
    used = msg_len[5:0];
    blk[used] = PAD_BYTE;
    used++;
    if (used > LEN_OFFSET) begin
      for (int i = used; i < 64; i++) blk[i] = 8'h00;
      compress();
      used = 0;
    end
    for (int i = used; i < LEN_OFFSET; i++) blk[i] = 8'h00;
    bits = msg_len << 3;
    for (int i = 0; i < 8; i++) blk[LEN_OFFSET + i] = bits[8*i +: 8];
    compress();
    dg.lo = {chain[1], chain[0]};
    dg.hi = {chain[3], chain[2]};
    pending_digests.push_back(dg);
    init_chain();
  endtask

  // Check digests on acceptance
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digests.size() == 0) begin
        $error("unexpected digest %h %h", digest_first_half, digest_second_half);
        errors++;
      end else begin
        digest_t dg;
        dg = pending_digests.pop_front();
        if (digest_first_half !== dg.lo) begin
          $error("digest_first_half exp %h got %h", dg.lo, digest_first_half);
          errors++;
        end
        if (digest_second_half !== dg.hi) begin
          $error("digest_second_half exp %h got %h", dg.hi, digest_second_half);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern: mostly sticky random stalls, with rare none, light or heavy draws
  always @(posedge clk) begin
    int mode;
    mode = ($urandom_range(0, 199) == 0) ? $urandom_range(0, 2) : -1;
    if (rst) out_stall <= 1'b0;
    else begin
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= out_stall ? ($urandom_range(0, 2) != 0)
                                        : ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("md5_message_digest regression: fail");
      $finish;
    end
  end

  int burst_left = 0;

  // Drive one transaction with bursty gaps and wait for acceptance
  task automatic send_item(logic fn, logic [7:0] byte_val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 1)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    func      <= fn;
    data_byte <= byte_val;
    do @(posedge clk); while (in_stall);
    predict_digest(fn, byte_val);
  endtask

  // Random message of n bytes then finish
  task automatic send_message(int n);
    for (int i = 0; i < n; i++) send_item(FN_ABSORB, 8'($urandom));
    send_item(FN_FINISH, 8'($urandom));
  endtask

  stim_row_t dir_rows [$];
  int sent;

  initial begin
    stim_row_t r;
    digest_t typed;
    int n;
    init_chain();
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    // Directed table: empty message, back-to-back finish, "abc", extreme bytes
    dir_rows.push_back('{FN_FINISH, 8'hff, 1'b1,
                         64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9});
    dir_rows.push_back('{FN_FINISH, 8'h00, 1'b1,
                         64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9});
    dir_rows.push_back('{FN_ABSORB, 8'h61, 1'b0, 64'h0, 64'h0});
    dir_rows.push_back('{FN_ABSORB, 8'h62, 1'b0, 64'h0, 64'h0});
    dir_rows.push_back('{FN_ABSORB, 8'h63, 1'b0, 64'h0, 64'h0});
    dir_rows.push_back('{FN_FINISH, 8'h00, 1'b1,
                         64'hb04fd23c98500190, 64'h727fe1287d3f96d6});
    dir_rows.push_back('{FN_ABSORB, 8'h00, 1'b0, 64'h0, 64'h0});
    dir_rows.push_back('{FN_ABSORB, 8'hff, 1'b0, 64'h0, 64'h0});
    dir_rows.push_back('{FN_ABSORB, 8'h55, 1'b0, 64'h0, 64'h0});
    dir_rows.push_back('{FN_ABSORB, 8'haa, 1'b0, 64'h0, 64'h0});
    dir_rows.push_back('{FN_FINISH, 8'h00, 1'b0, 64'h0, 64'h0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_item(r.fn, r.byte_val);
      if (r.has_digest) begin
        void'(pending_digests.pop_back());
        typed.lo = r.lo;
        typed.hi = r.hi;
        pending_digests.push_back(typed);
      end
    end

    // Padding boundaries: lengths around 55/56/64 bytes
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);

    // Hold off until every digest has come
    in_valid <= 1'b0;
    wait (pending_digests.size() == 0);
    @(posedge clk);

    // Random messages, mostly short, some multi-block
    sent = 0;
    while (sent < 650) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 20);
      send_message(n);
      sent += n + 1;
    end
    in_valid <= 1'b0;

    wait (pending_digests.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("md5_message_digest regression: pass");
    else $display("md5_message_digest regression: fail");
    $finish;
  end

endmodule
